@@ rtl/rmj_pkg.sv @@
// Shared widths, types and saturation helper for the radar measurement Jacobian.
package rmj_pkg;
	localparam int DATA_W = 32;
	localparam int FRAC = 16;
	localparam int HALF_W = DATA_W / 2;
	localparam int S_W = 2 * DATA_W;
	localparam int T_W = 2 * DATA_W;
	localparam int RR_W = DATA_W + 4;
	localparam int DEN_W = 3 * DATA_W;
	localparam int NUM_W = 3 * DATA_W + FRAC;
	localparam int REM_W = DEN_W + 1;
	localparam int SQRT_STEPS = DATA_W;
	localparam int DIV_STEPS = DATA_W;
	localparam int DIV_LAT = DIV_STEPS + 1;
	localparam int N_DIV = 6;
	localparam int PIPE_D = 2 + SQRT_STEPS + 2 + DIV_LAT + 1;
	localparam int FLG_D = SQRT_STEPS + 2 + DIV_LAT;

	typedef struct packed {
		logic pn;
		logic qn;
		logic tn;
		logic zero;
	} flags_t;

	typedef struct packed {
		logic [DATA_W-1:0] pm;
		logic [DATA_W-1:0] qm;
		logic [T_W-1:0]    tm;
		logic [S_W-1:0]    s;
	} side_t;

	// {overflow, value}
	function automatic logic [DATA_W:0] sat_fn(input logic [DATA_W-1:0] q,
		input logic big, input logic neg);
		logic [DATA_W-1:0] lim;
		logic [DATA_W-1:0] m;
		logic              o;
		lim = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		if (big || q > lim) begin
			m = lim;
			o = 1'b1;
		end else begin
			m = q;
			o = 1'b0;
		end
		return {o, neg ? (~m + {{(DATA_W-1){1'b0}}, 1'b1}) : m};
	endfunction
endpackage

@@ rtl/rmj_sqrt_cell.sv @@
// One digit step of the integer square root chain.
module rmj_sqrt_cell
	import rmj_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [RR_W-1:0]   rem_i,
	input  logic [DATA_W-1:0] root_i,
	input  logic [S_W-1:0]    sbits_i,
	output logic [RR_W-1:0]   rem_o,
	output logic [DATA_W-1:0] root_o,
	output logic [S_W-1:0]    sbits_o
);
	logic [RR_W-1:0] cur;
	logic [RR_W-1:0] trial;
	logic            ge;

	assign cur = {rem_i[RR_W-3:0], sbits_i[S_W-1:S_W-2]};
	assign trial = {{(RR_W-DATA_W-2){1'b0}}, root_i, 2'b01};
	assign ge = cur >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? cur - trial : cur;
			root_o <= {root_i[DATA_W-2:0], ge};
			sbits_o <= {sbits_i[S_W-3:0], 2'b00};
		end
	end
endmodule

@@ rtl/rmj_sqrt.sv @@
// Floor square root as a row of digit cells, one result bit per cell.
module rmj_sqrt
	import rmj_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [S_W-1:0]    s,
	output logic [DATA_W-1:0] root
);
	logic [RR_W-1:0]   rem_w [SQRT_STEPS+1];
	logic [DATA_W-1:0] root_w [SQRT_STEPS+1];
	logic [S_W-1:0]    sb_w [SQRT_STEPS+1];

	assign rem_w[0] = '0;
	assign root_w[0] = '0;
	assign sb_w[0] = s;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_cell
		rmj_sqrt_cell u_cell (
			.clk(clk), .en(en),
			.rem_i(rem_w[i]), .root_i(root_w[i]), .sbits_i(sb_w[i]),
			.rem_o(rem_w[i+1]), .root_o(root_w[i+1]), .sbits_o(sb_w[i+1])
		);
	end

	assign root = root_w[SQRT_STEPS];
endmodule

@@ rtl/rmj_div_cell.sv @@
// One restoring division step: one quotient bit per cell.
module rmj_div_cell
	import rmj_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [REM_W-1:0]  rem_i,
	input  logic [DATA_W-1:0] nbits_i,
	input  logic [DATA_W-1:0] q_i,
	input  logic [DEN_W-1:0]  den_i,
	input  logic              big_i,
	output logic [REM_W-1:0]  rem_o,
	output logic [DATA_W-1:0] nbits_o,
	output logic [DATA_W-1:0] q_o,
	output logic [DEN_W-1:0]  den_o,
	output logic              big_o
);
	logic [REM_W-1:0] cur;
	logic [REM_W-1:0] dx;
	logic             ge;

	assign cur = {rem_i[REM_W-2:0], nbits_i[DATA_W-1]};
	assign dx = {1'b0, den_i};
	assign ge = cur >= dx;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? cur - dx : cur;
			nbits_o <= {nbits_i[DATA_W-2:0], 1'b0};
			q_o <= {q_i[DATA_W-2:0], ge};
			den_o <= den_i;
			big_o <= big_i;
		end
	end
endmodule

@@ rtl/rmj_div.sv @@
// Divider: quotient range check, then a row of restoring cells.
module rmj_div
	import rmj_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [DATA_W-1:0] quo,
	output logic              big
);
	logic [REM_W-1:0]  rem_w [DIV_STEPS+1];
	logic [DATA_W-1:0] nb_w [DIV_STEPS+1];
	logic [DATA_W-1:0] q_w [DIV_STEPS+1];
	logic [DEN_W-1:0]  d_w [DIV_STEPS+1];
	logic              b_w [DIV_STEPS+1];
	logic [REM_W-1:0]  rem0_q;
	logic [DATA_W-1:0] nb0_q;
	logic [DEN_W-1:0]  d0_q;
	logic              b0_q;

	// quotient does not fit DATA_W bits when num >= den * 2^DATA_W
	always_ff @(posedge clk) begin
		if (en) begin
			b0_q <= {{(DEN_W+DATA_W-NUM_W){1'b0}}, num} >= {den, {DATA_W{1'b0}}};
			rem0_q <= {{(REM_W-NUM_W+DATA_W){1'b0}}, num[NUM_W-1:DATA_W]};
			nb0_q <= num[DATA_W-1:0];
			d0_q <= den;
		end
	end

	assign b_w[0] = b0_q;
	assign rem_w[0] = rem0_q;
	assign nb_w[0] = nb0_q;
	assign d_w[0] = d0_q;
	assign q_w[0] = '0;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		rmj_div_cell u_cell (
			.clk(clk), .en(en),
			.rem_i(rem_w[i]), .nbits_i(nb_w[i]), .q_i(q_w[i]), .den_i(d_w[i]),
			.big_i(b_w[i]),
			.rem_o(rem_w[i+1]), .nbits_o(nb_w[i+1]), .q_o(q_w[i+1]), .den_o(d_w[i+1]),
			.big_o(b_w[i+1])
		);
	end

	assign quo = q_w[DIV_STEPS];
	assign big = b_w[DIV_STEPS];
endmodule

@@ rtl/radar_measurement_jacobian_top.sv @@
// Radar measurement Jacobian: pipelined multiply, root and divide cell chains.
// Stages from input transfer to result valid: 1 multiply, 1 sum, 32 root cells,
// 2 wide multiply, 1 range check, 32 divide cells, 1 output.
// Throughput: one item per cycle; the whole pipe advances together and holds
// while a result waits at the output register.
// Reset: arst_n clears all valid bits; data registers are not reset.
module radar_measurement_jacobian_top
	import rmj_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] pos_x,
	input  logic signed [DATA_W-1:0] pos_y,
	input  logic signed [DATA_W-1:0] vel_x,
	input  logic signed [DATA_W-1:0] vel_y,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] range_by_px,
	output logic signed [DATA_W-1:0] range_by_py,
	output logic signed [DATA_W-1:0] bearing_by_px,
	output logic signed [DATA_W-1:0] bearing_by_py,
	output logic signed [DATA_W-1:0] rate_by_px,
	output logic signed [DATA_W-1:0] rate_by_py,
	output logic                     zero_position,
	output logic                     overflow
);
	logic              adv;
	logic [PIPE_D-1:0] vld_q;

	assign adv = !vld_q[PIPE_D-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[PIPE_D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_D-2:0], in_valid};
		end
	end

	// stage 1: magnitudes and products
	logic [DATA_W-1:0]     pm_s1, qm_s1;
	logic                  pn_s1, qn_s1;
	logic [S_W-1:0]        pp_s1, qq_s1;
	logic signed [T_W-1:0] uq_s1, wp_s1;
	logic [DATA_W-1:0]     pm_c, qm_c;

	assign pm_c = pos_x[DATA_W-1] ? DATA_W'(-pos_x) : DATA_W'(pos_x);
	assign qm_c = pos_y[DATA_W-1] ? DATA_W'(-pos_y) : DATA_W'(pos_y);

	always_ff @(posedge clk) begin
		if (adv) begin
			pm_s1 <= pm_c;
			qm_s1 <= qm_c;
			pn_s1 <= pos_x[DATA_W-1];
			qn_s1 <= pos_y[DATA_W-1];
			pp_s1 <= pm_c * pm_c;
			qq_s1 <= qm_c * qm_c;
			uq_s1 <= vel_x * pos_y;
			wp_s1 <= vel_y * pos_x;
		end
	end

	// stage 2: squared range and cross term
	logic [S_W-1:0] s_s2;
	logic [T_W-1:0] t_c;
	side_t          side_s2;
	flags_t         flg_s2;

	assign t_c = T_W'(uq_s1 - wp_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s2 <= pp_s1 + qq_s1;
			side_s2.pm <= pm_s1;
			side_s2.qm <= qm_s1;
			side_s2.tm <= t_c[T_W-1] ? -t_c : t_c;
			side_s2.s <= pp_s1 + qq_s1;
			flg_s2.pn <= pn_s1;
			flg_s2.qn <= qn_s1;
			flg_s2.tn <= t_c[T_W-1];
			flg_s2.zero <= (pm_s1 == '0) && (qm_s1 == '0);
		end
	end

	logic [DATA_W-1:0] r_w;

	rmj_sqrt u_sqrt (.clk(clk), .en(adv), .s(s_s2), .root(r_w));

	side_t  side_q [SQRT_STEPS];
	flags_t flg_q [FLG_D];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_s2;
			for (int i = 1; i < SQRT_STEPS; i++) side_q[i] <= side_q[i-1];
			flg_q[0] <= flg_s2;
			for (int i = 1; i < FLG_D; i++) flg_q[i] <= flg_q[i-1];
		end
	end

	// wide products as 32x32 partial products
	side_t             sd;
	logic [DATA_W-1:0] r_m1;
	logic [S_W-1:0]    ds_lo_m1, ds_hi_m1, qt_lo_m1, qt_hi_m1, pt_lo_m1, pt_hi_m1;
	logic [DATA_W-1:0] pm_m1, qm_m1;
	logic [S_W-1:0]    s_m1;

	assign sd = side_q[SQRT_STEPS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			r_m1 <= r_w;
			pm_m1 <= sd.pm;
			qm_m1 <= sd.qm;
			s_m1 <= sd.s;
			ds_lo_m1 <= sd.s[DATA_W-1:0] * r_w;
			ds_hi_m1 <= sd.s[S_W-1:DATA_W] * r_w;
			qt_lo_m1 <= sd.qm * sd.tm[DATA_W-1:0];
			qt_hi_m1 <= sd.qm * sd.tm[T_W-1:DATA_W];
			pt_lo_m1 <= sd.pm * sd.tm[DATA_W-1:0];
			pt_hi_m1 <= sd.pm * sd.tm[T_W-1:DATA_W];
		end
	end

	logic [NUM_W-1:0] num_m2 [N_DIV];
	logic [DEN_W-1:0] den_m2 [N_DIV];
	logic [DEN_W-1:0] dd_c, qt_c, pt_c;

	assign dd_c = {{DATA_W{1'b0}}, ds_lo_m1} + {ds_hi_m1, {DATA_W{1'b0}}};
	assign qt_c = {{DATA_W{1'b0}}, qt_lo_m1} + {qt_hi_m1, {DATA_W{1'b0}}};
	assign pt_c = {{DATA_W{1'b0}}, pt_lo_m1} + {pt_hi_m1, {DATA_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (adv) begin
			num_m2[0] <= {{(NUM_W-DATA_W-FRAC){1'b0}}, pm_m1, {FRAC{1'b0}}};
			num_m2[1] <= {{(NUM_W-DATA_W-FRAC){1'b0}}, qm_m1, {FRAC{1'b0}}};
			num_m2[2] <= {{(NUM_W-DATA_W-2*FRAC){1'b0}}, qm_m1, {(2*FRAC){1'b0}}};
			num_m2[3] <= {{(NUM_W-DATA_W-2*FRAC){1'b0}}, pm_m1, {(2*FRAC){1'b0}}};
			num_m2[4] <= {qt_c, {FRAC{1'b0}}};
			num_m2[5] <= {pt_c, {FRAC{1'b0}}};
			den_m2[0] <= {{(DEN_W-DATA_W){1'b0}}, r_m1};
			den_m2[1] <= {{(DEN_W-DATA_W){1'b0}}, r_m1};
			den_m2[2] <= {{(DEN_W-S_W){1'b0}}, s_m1};
			den_m2[3] <= {{(DEN_W-S_W){1'b0}}, s_m1};
			den_m2[4] <= dd_c;
			den_m2[5] <= dd_c;
		end
	end

	logic [DATA_W-1:0] quo_w [N_DIV];
	logic              big_w [N_DIV];

	for (genvar k = 0; k < N_DIV; k++) begin : g_div
		rmj_div u_div (
			.clk(clk), .en(adv), .num(num_m2[k]), .den(den_m2[k]),
			.quo(quo_w[k]), .big(big_w[k])
		);
	end

	// sign and saturation
	flags_t          fl;
	logic            neg_c [N_DIV];
	logic [DATA_W:0] sat_c [N_DIV];

	assign fl = flg_q[FLG_D-1];
	assign neg_c[0] = fl.pn;
	assign neg_c[1] = fl.qn;
	assign neg_c[2] = !fl.qn;
	assign neg_c[3] = fl.pn;
	assign neg_c[4] = fl.qn != fl.tn;
	assign neg_c[5] = fl.pn == fl.tn;

	for (genvar k = 0; k < N_DIV; k++) begin : g_sat
		assign sat_c[k] = sat_fn(quo_w[k], big_w[k], neg_c[k]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_position <= fl.zero;
			if (fl.zero) begin
				range_by_px <= '0;
				range_by_py <= '0;
				bearing_by_px <= '0;
				bearing_by_py <= '0;
				rate_by_px <= '0;
				rate_by_py <= '0;
				overflow <= 1'b0;
			end else begin
				range_by_px <= sat_c[0][DATA_W-1:0];
				range_by_py <= sat_c[1][DATA_W-1:0];
				bearing_by_px <= sat_c[2][DATA_W-1:0];
				bearing_by_py <= sat_c[3][DATA_W-1:0];
				rate_by_px <= sat_c[4][DATA_W-1:0];
				rate_by_py <= sat_c[5][DATA_W-1:0];
				overflow <= sat_c[0][DATA_W] | sat_c[1][DATA_W] | sat_c[2][DATA_W]
					| sat_c[3][DATA_W] | sat_c[4][DATA_W] | sat_c[5][DATA_W];
			end
		end
	end

	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_position |-> !overflow && range_by_px == '0
			&& rate_by_py == '0 && bearing_by_py == '0)
		else $error("zero position result not cleared");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_position |->
			range_by_px <= (32'sd1 <<< FRAC) && range_by_px >= -(32'sd1 <<< FRAC)
			&& range_by_py <= (32'sd1 <<< FRAC) && range_by_py >= -(32'sd1 <<< FRAC))
		else $error("range partial exceeds unit magnitude");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(rate_by_px) && $stable(overflow))
		else $error("result changed while stalled");
endmodule

@@ sim/rmj_checker.sv @@
// Checker for the radar measurement Jacobian: predicts each result and compares transfers.
`timescale 1ns / 1ps
module rmj_checker
	import rmj_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [DATA_W-1:0] pos_x,
	input  logic signed [DATA_W-1:0] pos_y,
	input  logic signed [DATA_W-1:0] vel_x,
	input  logic signed [DATA_W-1:0] vel_y,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [DATA_W-1:0] range_by_px,
	input  logic signed [DATA_W-1:0] range_by_py,
	input  logic signed [DATA_W-1:0] bearing_by_px,
	input  logic signed [DATA_W-1:0] bearing_by_py,
	input  logic signed [DATA_W-1:0] rate_by_px,
	input  logic signed [DATA_W-1:0] rate_by_py,
	input  logic                     zero_position,
	input  logic                     overflow,
	output int                       errors,
	output int                       pending,
	output int                       n_checked,
	output int                       n_saturated,
	output int                       n_zero
);
	typedef struct {
		logic [DATA_W-1:0] r_px;
		logic [DATA_W-1:0] r_py;
		logic [DATA_W-1:0] b_px;
		logic [DATA_W-1:0] b_py;
		logic [DATA_W-1:0] t_px;
		logic [DATA_W-1:0] t_py;
		logic              zero;
		logic              ovf;
	} jac_t;

	jac_t jac_due[$];

	function automatic logic [63:0] root_floor(input logic [127:0] s);
		logic [63:0] root;
		logic [63:0] c;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			c = root | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= s)
				root = c;
		end
		return root;
	endfunction

	// {saturated, value}
	function automatic logic [DATA_W:0] clamp_q(input logic [127:0] mag, input logic neg);
		logic [127:0] lim;
		logic [DATA_W-1:0] v;
		logic o;
		lim = neg ? (128'd1 << (DATA_W - 1)) : ((128'd1 << (DATA_W - 1)) - 1);
		o = mag > lim;
		v = o ? lim[DATA_W-1:0] : mag[DATA_W-1:0];
		return {o, neg ? -v : v};
	endfunction

	function automatic jac_t jacobian_predict(input logic signed [DATA_W-1:0] px,
		input logic signed [DATA_W-1:0] py, input logic signed [DATA_W-1:0] vx,
		input logic signed [DATA_W-1:0] vy);
		jac_t e;
		logic signed [127:0] p, q, u, w, t;
		logic [127:0] pm, qm, tm, s, r, d;
		logic pn, qn, tn;
		logic [DATA_W:0] c0, c1, c2, c3, c4, c5;
		p = px;
		q = py;
		u = vx;
		w = vy;
		pn = p < 0;
		qn = q < 0;
		pm = pn ? -p : p;
		qm = qn ? -q : q;
		s = pm * pm + qm * qm;
		e = '{default: '0};
		if (s == 0) begin
			e.zero = 1'b1;
			return e;
		end
		r = root_floor(s);
		t = u * q - w * p;
		tn = t < 0;
		tm = tn ? -t : t;
		d = s * r;
		c0 = clamp_q((pm << FRAC) / r, pn);
		c1 = clamp_q((qm << FRAC) / r, qn);
		c2 = clamp_q((qm << (2 * FRAC)) / s, !qn);
		c3 = clamp_q((pm << (2 * FRAC)) / s, pn);
		c4 = clamp_q(((qm * tm) << FRAC) / d, qn != tn);
		c5 = clamp_q(((pm * tm) << FRAC) / d, pn == tn);
		e.r_px = c0[DATA_W-1:0];
		e.r_py = c1[DATA_W-1:0];
		e.b_px = c2[DATA_W-1:0];
		e.b_py = c3[DATA_W-1:0];
		e.t_px = c4[DATA_W-1:0];
		e.t_py = c5[DATA_W-1:0];
		e.ovf = c0[DATA_W] | c1[DATA_W] | c2[DATA_W] | c3[DATA_W] | c4[DATA_W] | c5[DATA_W];
		return e;
	endfunction

	task automatic report(input string what, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		n_checked = 0;
		n_saturated = 0;
		n_zero = 0;
	end

	assign pending = jac_due.size();

	always @(posedge clk) begin
		jac_t e;
		if (arst_n) begin
			if (in_valid && in_ready)
				jac_due.push_back(jacobian_predict(pos_x, pos_y, vel_x, vel_y));
			if (out_valid && out_ready) begin
				if (jac_due.size() == 0) begin
					report("unexpected transfer", '0, '0);
				end else begin
					e = jac_due.pop_front();
					n_checked++;
					if (e.ovf) n_saturated++;
					if (e.zero) n_zero++;
					if (range_by_px !== e.r_px) report("range_by_px", range_by_px, e.r_px);
					if (range_by_py !== e.r_py) report("range_by_py", range_by_py, e.r_py);
					if (bearing_by_px !== e.b_px)
						report("bearing_by_px", bearing_by_px, e.b_px);
					if (bearing_by_py !== e.b_py)
						report("bearing_by_py", bearing_by_py, e.b_py);
					if (rate_by_px !== e.t_px) report("rate_by_px", rate_by_px, e.t_px);
					if (rate_by_py !== e.t_py) report("rate_by_py", rate_by_py, e.t_py);
					if (zero_position !== e.zero)
						report("zero_position", DATA_W'(zero_position), DATA_W'(e.zero));
					if (overflow !== e.ovf)
						report("overflow", DATA_W'(overflow), DATA_W'(e.ovf));
				end
			end
		end
	end
endmodule

@@ sim/tb_radar_measurement_jacobian_top.sv @@
// Testbench top for the radar measurement Jacobian: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_radar_measurement_jacobian_top
	import rmj_pkg::*;
();

	localparam int N_RANDOM = 450;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int LAT = 70;
	localparam logic signed [DATA_W-1:0] MAXV = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] MINV = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] ONE = 1 <<< FRAC;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [DATA_W-1:0] pos_x, pos_y, vel_x, vel_y;
	logic signed [DATA_W-1:0] range_by_px, range_by_py, bearing_by_px, bearing_by_py;
	logic signed [DATA_W-1:0] rate_by_px, rate_by_py;
	logic zero_position, overflow;
	int errors, pending, n_checked, n_saturated, n_zero;
	int n_sent;
	int cycles;
	logic calm;
	logic hold_go;
	int hold_cnt;

	radar_measurement_jacobian_top dut (.*);

	rmj_checker u_checker (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		cycles = 0;
	end
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off
	initial begin
		out_ready = 1'b0;
		hold_cnt = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_go && hold_cnt == 0) hold_cnt = HOLD_CYCLES;
			if (hold_cnt > 0) begin
				out_ready <= 1'b0;
				hold_cnt--;
				if (hold_cnt == 0) hold_go = 1'b0;
			end else begin
				out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
			end
		end
	end

	task automatic send(input logic signed [DATA_W-1:0] px, input logic signed [DATA_W-1:0] py,
		input logic signed [DATA_W-1:0] vx, input logic signed [DATA_W-1:0] vy);
		if (!calm) begin
			while ($urandom_range(99) < 35) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		pos_x <= px;
		pos_y <= py;
		vel_x <= vx;
		vel_y <= vy;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_sent++;
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value(input int kind);
		case (kind)
			0: return $urandom;
			1: return $signed($urandom_range(4 * ONE)) - 2 * ONE;
			2: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
			3: return $signed($urandom_range(255)) - 128;
			default: return '0;
		endcase
	endfunction

	initial begin
		int k, kp, kv;
		logic signed [DATA_W-1:0] px, py;
		calm = 1'b0;
		hold_go = 1'b0;
		n_sent = 0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		vel_x = '0;
		vel_y = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero position, unit axes, tiny and extreme magnitudes
		send(0, 0, MAXV, MINV);
		send(0, 0, 0, 0);
		send(ONE, 0, ONE, ONE);
		send(0, ONE, -ONE, ONE);
		send(-ONE, 0, 0, -ONE);
		send(0, -ONE, ONE, 0);
		send(1, 0, 0, 0);
		send(0, -1, MAXV, MAXV);
		send(1, 1, MINV, MAXV);
		send(-1, 1, MAXV, MINV);
		send(MAXV, MAXV, MAXV, MAXV);
		send(MINV, MINV, MINV, MINV);
		send(MINV, MAXV, MAXV, MINV);
		send(MAXV, MINV, MINV, MAXV);
		send(MINV, 0, MINV, MINV);
		send(0, MINV, MAXV, MINV);
		send(3 * ONE, 4 * ONE, ONE, -2 * ONE);
		send(-3 * ONE, 4 * ONE, 5 * ONE, 7 * ONE);
		send(2, -3, MAXV, MINV);
		send(ONE, ONE, ONE, ONE);
		send(-1, -1, -1, -1);

		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 100 && i < 160);
			if (i == 250) hold_go = 1'b1;
			if (i == 350) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			kp = $urandom_range(3);
			kv = $urandom_range(3);
			px = pick_value(kp);
			py = pick_value($urandom_range(3));
			k = $urandom_range(19);
			if (k == 0) begin
				px = 0;
				py = 0;
			end else if (k == 1) begin
				px = 0;
			end else if (k == 2) begin
				py = 0;
			end
			send(px, py, pick_value(kv), pick_value($urandom_range(3)));
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		$display("sent %0d state vectors, checked %0d Jacobians", n_sent, n_checked);
		$display("  %0d saturated, %0d zero position, long output hold-off and drain pause",
			n_saturated, n_zero);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
